// ===== rtl/host_power_shutdown_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Host power shutdown sequencer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HOST_POWER_SHUTDOWN_SEQUENCER_ASSERT_SVH
`define HOST_POWER_SHUTDOWN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPSS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HPSS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/hpss_pkg.sv =====
// ----------------------------------------------------------------------------
// Host power shutdown sequencer package
// Shared types, register map, reset values and output codes.
// ----------------------------------------------------------------------------
package hpss_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 16;

    localparam logic [1:0] CFG_IDX_RESPONSE = 2'd0;
    localparam logic [1:0] CFG_IDX_FINAL    = 2'd1;
    localparam logic [1:0] CFG_IDX_DEBOUNCE = 2'd2;

    localparam logic [CNT_W-1:0] RESPONSE_TIMEOUT_RST = 16'd6000;
    localparam logic [CNT_W-1:0] FINAL_WAIT_RST       = 16'd500;
    localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST   = 16'd150;
    localparam logic [CNT_W-1:0] CNT_MAX              = 16'hFFFF;

    localparam logic [2:0] LED_OFF   = 3'd0;
    localparam logic [2:0] LED_SOLID = 3'd1;
    localparam logic [2:0] LED_SLOW  = 3'd2;
    localparam logic [2:0] LED_FAST  = 3'd3;
    localparam logic [2:0] LED_VFAST = 3'd4;
    localparam logic [2:0] LED_DIM   = 3'd5;

    localparam logic [2:0] SEQ_BOOT  = 3'd0;
    localparam logic [2:0] SEQ_RUN   = 3'd1;
    localparam logic [2:0] SEQ_SHUT  = 3'd2;
    localparam logic [2:0] SEQ_BACK  = 3'd3;
    localparam logic [2:0] SEQ_FINAL = 3'd4;
    localparam logic [2:0] SEQ_KILL  = 3'd5;

    typedef enum logic [5:0] {
        PH_BOOT  = 6'b000001,
        PH_RUN   = 6'b000010,
        PH_SHUT  = 6'b000100,
        PH_BACK  = 6'b001000,
        PH_FINAL = 6'b010000,
        PH_KILL  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0] response_timeout;
        logic [CNT_W-1:0] final_wait;
        logic [CNT_W-1:0] debounce_ticks;
    } cfg_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_BOOT:  code = SEQ_BOOT;
            PH_RUN:   code = SEQ_RUN;
            PH_SHUT:  code = SEQ_SHUT;
            PH_BACK:  code = SEQ_BACK;
            PH_FINAL: code = SEQ_FINAL;
            PH_KILL:  code = SEQ_KILL;
            default:  code = SEQ_BOOT;
        endcase
        return code;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/hpss_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the timeout and debounce limits.
// ----------------------------------------------------------------------------
module hpss_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpss_pkg::ADDR_W-1:0] paddr,
    input  logic [hpss_pkg::DATA_W-1:0] pwdata,
    output logic [hpss_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output hpss_pkg::cfg_t              cfg
);

    hpss_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.response_timeout <= hpss_pkg::RESPONSE_TIMEOUT_RST;
            cfg_reg.final_wait       <= hpss_pkg::FINAL_WAIT_RST;
            cfg_reg.debounce_ticks   <= hpss_pkg::DEBOUNCE_TICKS_RST;
        end else if (wr_en) begin
            unique case (idx)
                hpss_pkg::CFG_IDX_RESPONSE: cfg_reg.response_timeout <= pwdata[15:0];
                hpss_pkg::CFG_IDX_FINAL:    cfg_reg.final_wait       <= pwdata[15:0];
                hpss_pkg::CFG_IDX_DEBOUNCE: cfg_reg.debounce_ticks   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            hpss_pkg::CFG_IDX_RESPONSE: prdata = {16'd0, cfg_reg.response_timeout};
            hpss_pkg::CFG_IDX_FINAL:    prdata = {16'd0, cfg_reg.final_wait};
            hpss_pkg::CFG_IDX_DEBOUNCE: prdata = {16'd0, cfg_reg.debounce_ticks};
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== rtl/hpss_debounce.sv =====
// ----------------------------------------------------------------------------
// Ignition debouncer
// Accepts a new ignition level once the raw level has held long enough.
// ----------------------------------------------------------------------------
module hpss_debounce (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       tick,
    input  logic                       ignition_raw,
    input  logic [hpss_pkg::CNT_W-1:0] debounce_ticks,
    output logic                       ignition_stable
);

    logic                       stable_reg;
    logic                       stable_next;
    logic                       last_reg;
    logic                       last_next;
    logic [hpss_pkg::CNT_W-1:0] count_reg;
    logic [hpss_pkg::CNT_W-1:0] count_next;
    logic [hpss_pkg::CNT_W-1:0] count_inc;

    assign ignition_stable = stable_reg;
    assign count_inc       = hpss_pkg::sat_inc(count_reg);

    always_comb begin
        stable_next = stable_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        if (ignition_raw != last_reg) begin
            last_next  = ignition_raw;
            count_next = '0;
        end else if (count_inc >= debounce_ticks && ignition_raw != stable_reg) begin
            stable_next = ignition_raw;
            count_next  = '0;
        end else begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg <= 1'b1;
            last_reg   <= 1'b1;
            count_reg  <= '0;
        end else if (tick) begin
            stable_reg <= stable_next;
            last_reg   <= last_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/hpss_seq.sv =====
// ----------------------------------------------------------------------------
// Power sequence state machine
// Six-phase power sequence with a saturating phase timer and LED mode.
// ----------------------------------------------------------------------------
module hpss_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           tick,
    input  logic           host_ready,
    input  logic           ignition_stable,
    input  hpss_pkg::cfg_t cfg,
    output logic           power_enable,
    output logic           shutdown_request,
    output logic [2:0]     led_mode,
    output logic [2:0]     sequence_state
);

    hpss_pkg::phase_t           phase_reg;
    hpss_pkg::phase_t           phase_next;
    logic [hpss_pkg::CNT_W-1:0] elapsed_reg;
    logic [hpss_pkg::CNT_W-1:0] elapsed_next;
    logic [hpss_pkg::CNT_W-1:0] elapsed_inc;
    logic                       power_reg;
    logic                       power_next;
    logic                       shut_reg;
    logic                       shut_next;
    logic [2:0]                 led_reg;
    logic [2:0]                 led_next;
    logic                       resp_to;
    logic                       final_to;

    assign elapsed_inc = hpss_pkg::sat_inc(elapsed_reg);
    assign resp_to     = elapsed_inc > cfg.response_timeout;
    assign final_to    = elapsed_inc > cfg.final_wait;

    always_comb begin
        phase_next = phase_reg;
        power_next = power_reg;
        shut_next  = shut_reg;
        led_next   = hpss_pkg::LED_OFF;
        unique case (phase_reg)
            hpss_pkg::PH_BOOT: begin
                led_next = hpss_pkg::LED_SLOW;
                if (host_ready) begin
                    phase_next = hpss_pkg::PH_RUN;
                end else if (resp_to) begin
                    phase_next = hpss_pkg::PH_FINAL;
                end
            end
            hpss_pkg::PH_RUN: begin
                led_next = hpss_pkg::LED_SOLID;
                if (!ignition_stable) begin
                    shut_next  = 1'b1;
                    phase_next = hpss_pkg::PH_SHUT;
                end else if (!host_ready) begin
                    phase_next = hpss_pkg::PH_BACK;
                end
            end
            hpss_pkg::PH_SHUT: begin
                led_next = hpss_pkg::LED_FAST;
                if (!host_ready || resp_to) begin
                    phase_next = hpss_pkg::PH_FINAL;
                end
            end
            hpss_pkg::PH_BACK: begin
                led_next = hpss_pkg::LED_VFAST;
                if (host_ready) begin
                    phase_next = hpss_pkg::PH_RUN;
                end else if (resp_to) begin
                    phase_next = hpss_pkg::PH_FINAL;
                end
            end
            hpss_pkg::PH_FINAL: begin
                led_next = hpss_pkg::LED_DIM;
                if (final_to) begin
                    phase_next = hpss_pkg::PH_KILL;
                end
            end
            hpss_pkg::PH_KILL: begin
                led_next   = hpss_pkg::LED_OFF;
                power_next = 1'b0;
                if (ignition_stable) begin
                    power_next = 1'b1;
                    shut_next  = 1'b0;
                    phase_next = hpss_pkg::PH_BOOT;
                end
            end
            default: begin
                led_next   = hpss_pkg::LED_OFF;
                phase_next = hpss_pkg::PH_BOOT;
            end
        endcase
        elapsed_next = (phase_next != phase_reg) ? '0 : elapsed_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= hpss_pkg::PH_BOOT;
            elapsed_reg <= '0;
            power_reg   <= 1'b1;
            shut_reg    <= 1'b0;
            led_reg     <= hpss_pkg::LED_OFF;
        end else if (tick) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            power_reg   <= power_next;
            shut_reg    <= shut_next;
            led_reg     <= led_next;
        end
    end

    assign power_enable     = power_reg;
    assign shutdown_request = shut_reg;
    assign led_mode         = led_reg;
    assign sequence_state   = hpss_pkg::phase_code(phase_reg);

endmodule

// ===== rtl/host_power_shutdown_sequencer.sv =====
// Timing: a result beat is valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the sequence and debounce registers update
// once per accepted beat; a pending result stalls input until m_ready takes it.
// Reset: synchronous active-low aresetn returns to boot wait with power on,
// ignition assumed on, limits at their defaults and no result pending.
// ----------------------------------------------------------------------------
// Host power shutdown sequencer top level
// Debounces ignition and steps the host power sequence once per tick beat.
// ----------------------------------------------------------------------------
module host_power_shutdown_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_ignition_raw,
    input  logic                        s_host_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_power_enable,
    output logic                        m_shutdown_request,
    output logic [2:0]                  m_led_mode,
    output logic [2:0]                  m_sequence_state,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpss_pkg::ADDR_W-1:0] paddr,
    input  logic [hpss_pkg::DATA_W-1:0] pwdata,
    output logic [hpss_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    hpss_pkg::cfg_t cfg;
    logic           tick;
    logic           ignition_stable;
    logic           m_valid_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign tick    = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tick) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    hpss_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpss_debounce u_debounce (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick            (tick),
        .ignition_raw    (s_ignition_raw),
        .debounce_ticks  (cfg.debounce_ticks),
        .ignition_stable (ignition_stable)
    );

    hpss_seq u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick             (tick),
        .host_ready       (s_host_ready),
        .ignition_stable  (ignition_stable),
        .cfg              (cfg),
        .power_enable     (m_power_enable),
        .shutdown_request (m_shutdown_request),
        .led_mode         (m_led_mode),
        .sequence_state   (m_sequence_state)
    );

endmodule

// ===== rtl/hpss_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the sequencer ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "host_power_shutdown_sequencer_assert.svh"

module hpss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_power_enable,
    input logic       m_shutdown_request,
    input logic [2:0] m_led_mode,
    input logic [2:0] m_sequence_state
);

    logic [7:0] m_payload;
    logic       m_in_kill;
    logic       m_in_run;
    logic       m_led_on;

    assign m_payload = {m_power_enable, m_shutdown_request, m_led_mode, m_sequence_state};
    assign m_in_kill = (m_sequence_state == hpss_pkg::SEQ_KILL);
    assign m_in_run  = (m_sequence_state == hpss_pkg::SEQ_RUN);
    assign m_led_on  = (m_led_mode != hpss_pkg::LED_OFF);

    `HPSS_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    `HPSS_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)
    `HPSS_ASSERT_NOW(a_powered_outside_kill, aclk, aresetn, m_valid && !m_in_kill, m_power_enable)
    `HPSS_ASSERT_NOW(a_run_powered, aclk, aresetn, m_valid && m_in_run, m_power_enable && m_led_on)

endmodule

bind host_power_shutdown_sequencer hpss_checker u_hpss_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_power_enable     (m_power_enable),
    .m_shutdown_request (m_shutdown_request),
    .m_led_mode         (m_led_mode),
    .m_sequence_state   (m_sequence_state)
);
